// File: hdl/lsne_pkg.sv
// ----------------------------------------------------------------------------
// lsne_pkg
// Shared constants and types for the LED strip NRZ frame encoder.
// ----------------------------------------------------------------------------
package lsne_pkg;

    localparam int RESET_LENGTH   = 32;
    localparam int BITS_PER_PIXEL = 24;
    localparam int CNT_W          = $clog2(BITS_PER_PIXEL + RESET_LENGTH);

    localparam logic [7:0] NRZ_ONE   = 8'hF0;
    localparam logic [7:0] NRZ_ZERO  = 8'hC0;
    localparam logic [7:0] LATCH_BYTE = 8'h00;

    localparam logic [CNT_W-1:0] PIXEL_END = CNT_W'(BITS_PER_PIXEL - 1);
    localparam logic [CNT_W-1:0] FRAME_END = CNT_W'(BITS_PER_PIXEL + RESET_LENGTH - 1);

    // Register byte-address index (paddr[2])
    localparam logic REG_BRIGHTNESS = 1'b0;

    typedef struct packed {
        logic [23:0] grb;
        logic        last;
    } lsne_load_t;

endpackage

// File: hdl/led_strip_nrz_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// led_strip_nrz_frame_encoder_unit
// Scale RGB pixels by brightness and encode them as NRZ SPI bytes.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  s_*       in         one pixel: red, green, blue; tlast = last pixel
//  m_*       out        one SPI byte; tlast = last byte of the pixel's run
//  APB       in         brightness register at byte address 0
//
//  A pixel expands to 24 output bytes, 24 + RESET_LENGTH when it closes
//  a frame; the serializer sets the rate, one byte per cycle unless stalled.
//  Scaling runs in three lanes (multiply, then reciprocal) ahead of it, so
//  the next pixel is taken while the current one is still being sent.
//  Output stalls hold the serializer; reset clears all valid flags and
//  sets brightness to 255.
// ----------------------------------------------------------------------------
module led_strip_nrz_frame_encoder_unit
    import lsne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic        s_tlast,   // last_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // spi_byte[7:0]
    output logic        m_tlast,   // run_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]  brightness_reg;
    logic        a_valid_reg;
    logic        a_last_reg;
    logic        b_valid_reg;
    logic        b_last_reg;
    logic [23:0] grb_reg;
    logic [7:0]  red_q, green_q, blue_q;
    logic        a_move, b_ready, in_take;
    logic        ser_ready;
    lsne_load_t  ser_load;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BRIGHTNESS) ? {24'd0, brightness_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 8'd255;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_BRIGHTNESS))
        begin
            brightness_reg <= pwdata[7:0];
        end
    end

    assign b_ready  = !b_valid_reg || ser_ready;
    assign a_move   = a_valid_reg && b_ready;
    assign s_tready = !a_valid_reg || a_move;
    assign in_take  = s_tvalid && s_tready;

    lsne_lane u_lane_red
    (
        .clk        (clk),
        .en         (in_take),
        .channel    (s_tdata[7:0]),
        .brightness (brightness_reg),
        .scaled     (red_q)
    );

    lsne_lane u_lane_green
    (
        .clk        (clk),
        .en         (in_take),
        .channel    (s_tdata[15:8]),
        .brightness (brightness_reg),
        .scaled     (green_q)
    );

    lsne_lane u_lane_blue
    (
        .clk        (clk),
        .en         (in_take),
        .channel    (s_tdata[23:16]),
        .brightness (brightness_reg),
        .scaled     (blue_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end

            if (a_move)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (ser_ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    // Merge lane results into GRB order
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_last_reg <= s_tlast;
        end
        if (a_move)
        begin
            grb_reg    <= {green_q, red_q, blue_q};
            b_last_reg <= a_last_reg;
        end
    end

    assign ser_load.grb  = grb_reg;
    assign ser_load.last = b_last_reg;

    lsne_serializer u_serializer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (b_valid_reg),
        .load       (ser_load),
        .load_ready (ser_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// File: hdl/lsne_lane.sv
// ----------------------------------------------------------------------------
// lsne_lane
// One color lane: registered channel*brightness product, then exact
// floor(product/255) through the add-and-shift reciprocal.
// ----------------------------------------------------------------------------
module lsne_lane
    import lsne_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] channel,
    input  logic [7:0] brightness,
    output logic [7:0] scaled
);

    logic [15:0] product_reg;
    logic [16:0] sum;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= channel * brightness;
        end
    end

    // floor(x/255) = (x + (x >> 8) + 1) >> 8 for x <= 255*255
    assign sum    = {1'b0, product_reg} + {9'd0, product_reg[15:8]} + 17'd1;
    assign scaled = sum[15:8];

endmodule

// File: hdl/lsne_serializer.sv
// ----------------------------------------------------------------------------
// lsne_serializer
// Expand a GRB pixel into NRZ SPI bytes, MSB first, plus latch bytes.
// ----------------------------------------------------------------------------
module lsne_serializer
    import lsne_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_valid,
    input  lsne_load_t  load,
    output logic        load_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // spi_byte[7:0]
    output logic        m_tlast    // run_end
);

    logic             busy_reg,  busy_next;
    logic [23:0]      shift_reg, shift_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             last_reg,  last_next;
    logic             ovalid_reg, ovalid_next;
    logic [7:0]       obyte_reg, obyte_next;
    logic             oend_reg,  oend_next;

    logic emit;
    logic is_end;
    logic take;

    assign emit   = busy_reg && (!ovalid_reg || m_tready);
    assign is_end = last_reg ? (count_reg == FRAME_END) : (count_reg == PIXEL_END);
    assign take   = load_valid && (!busy_reg || (emit && is_end));

    assign load_ready = !busy_reg || (emit && is_end);

    always_comb
    begin
        busy_next   = busy_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        oend_next   = oend_reg;

        if (m_tready)
        begin
            ovalid_next = 1'b0;
        end

        if (emit)
        begin
            ovalid_next = 1'b1;
            oend_next   = is_end;
            if (count_reg < PIXEL_END + CNT_W'(1))
            begin
                obyte_next = shift_reg[23] ? NRZ_ONE : NRZ_ZERO;
            end
            else
            begin
                obyte_next = LATCH_BYTE;
            end
            shift_next = {shift_reg[22:0], 1'b0};
            count_next = count_reg + CNT_W'(1);
            if (is_end)
            begin
                busy_next = 1'b0;
            end
        end

        if (take)
        begin
            busy_next  = 1'b1;
            shift_next = load.grb;
            last_next  = load.last;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
            count_reg  <= '0;
            last_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
            count_reg  <= count_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        obyte_reg <= obyte_next;
        oend_reg  <= oend_next;
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = obyte_reg;
    assign m_tlast  = oend_reg;

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for led_strip_nrz_frame_encoder_unit. Pixels go in through the
// slave stream and each expands to 24 NRZ SPI bytes, plus a latch run of zero
// bytes after the last pixel of a frame. A local model scales every channel
// by the brightness register and queues the bytes expected in G, R, B order.
// A checker compares each output transaction with the oldest entry in that
// queue. Directed pixels cover channel extremes, alternating bit patterns,
// single and back-to-back frame ends, and brightness from 0 to 255, plus
// writes to an unmapped register and writes with upper data bits set.
// Random frames follow with bursts of input gaps and output stalls; the last
// phase streams with no idling.
// ----------------------------------------------------------------------------
module testbench;
    import lsne_pkg::*;

    localparam int         WATCHDOG_LIMIT  = 1000;
    localparam int         RANDOM_PIXELS   = 140;
    localparam int         STREAM_PIXELS   = 20;
    localparam int         SETTLE_CYCLES   = 8;
    localparam int         TAIL_CYCLES     = 30;
    localparam logic [2:0] BRIGHTNESS_ADDR = {REG_BRIGHTNESS, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR   = 3'd4;

    typedef struct {
        logic [7:0] spi_byte;
        logic       run_end;
    } nrz_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    nrz_byte_t   nrz_expected_q[$];
    logic [7:0]  brightness_cfg;
    bit          idle_on;
    int          errors;
    int          pixels_sent;
    int          frames_sent;
    int          bytes_checked;
    int          register_writes;
    int          quiet_cycles;

    led_strip_nrz_frame_encoder_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (byte %0d)",
                 what, got, want, bytes_checked);
        errors++;
    endtask

    function automatic logic [7:0] scale_channel(input logic [7:0] level);
        logic [15:0] product;
        product = level * brightness_cfg;
        return 8'(product / 16'd255);
    endfunction

    function automatic void predict_pixel_bytes(input logic [7:0] red, input logic [7:0] green,
                                                input logic [7:0] blue, input logic last_pixel);
        logic [23:0] grb;
        nrz_byte_t   nb;
        grb = {scale_channel(green), scale_channel(red), scale_channel(blue)};
        for (int i = BITS_PER_PIXEL - 1; i >= 0; i--)
        begin
            nb.spi_byte = grb[i] ? NRZ_ONE : NRZ_ZERO;
            nb.run_end  = (i == 0) && !last_pixel;
            nrz_expected_q.insert(nrz_expected_q.size(), nb);
        end
        if (last_pixel)
        begin
            for (int i = 0; i < RESET_LENGTH; i++)
            begin
                nb.spi_byte = LATCH_BYTE;
                nb.run_end  = (i == RESET_LENGTH - 1);
                nrz_expected_q.insert(nrz_expected_q.size(), nb);
            end
        end
    endfunction

    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // check every output transaction against the oldest expected byte
    always @(posedge clk)
    begin
        nrz_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (nrz_expected_q.size() == 0)
                report_mismatch("unexpected output byte", m_tdata, 0);
            else
            begin
                want = nrz_expected_q.pop_front();
                if (m_tdata !== want.spi_byte)
                    report_mismatch("spi_byte", m_tdata, want.spi_byte);
                if (m_tlast !== want.run_end)
                    report_mismatch("run_end", m_tlast, want.run_end);
            end
            bytes_checked++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else if (rst_n)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired, %0d bytes still expected", nrz_expected_q.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // output stalls: random bursts separated by quiet stretches
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
                m_tready = 1'b1;
            end
            else if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(5, 40)) @(negedge clk);
        end
    end

    task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                              input logic [7:0] blue, input logic last_pixel);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 15);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {blue, green, red};
        s_tlast  = last_pixel;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_pixel_bytes(red, green, blue, last_pixel);
        pixels_sent++;
        if (last_pixel)
            frames_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (nrz_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write, then read back brightness to confirm the register contents
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == BRIGHTNESS_ADDR)
            brightness_cfg = data[7:0];
        register_writes++;
        @(negedge clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = BRIGHTNESS_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[7:0] !== brightness_cfg)
            report_mismatch("brightness readback", prdata[7:0], brightness_cfg);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic test_full_brightness();
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h55, 1'b1);
        send_pixel(8'hFF, 8'h00, 8'h80, 1'b1);
        send_pixel(8'h01, 8'hFE, 8'h7F, 1'b1);
        drain();
    endtask

    task automatic test_brightness_levels();
        logic [7:0] levels[5];
        levels = '{8'd0, 8'd1, 8'd128, 8'd254, 8'd255};
        foreach (levels[i])
        begin
            write_register(BRIGHTNESS_ADDR, {24'h0, levels[i]});
            send_pixel(8'hFF, 8'h80, 8'h01, 1'b0);
            send_pixel(8'h7F, 8'hFE, 8'hC3, 1'b1);
            drain();
        end
    endtask

    task automatic test_register_decode();
        write_register(BRIGHTNESS_ADDR, 32'hFFFF_FF40);
        write_register(UNMAPPED_ADDR, 32'h0000_0011);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'h9C, 8'h3A, 8'hE5, 1'b0);
        drain();
    endtask

    task automatic test_random_frames();
        int start;
        int frame_len;
        start   = pixels_sent;
        idle_on = 1'b1;
        while (pixels_sent - start < RANDOM_PIXELS)
        begin
            frame_len = $urandom_range(1, 6);
            for (int i = 0; i < frame_len; i++)
                send_pixel(pick_channel(), pick_channel(), pick_channel(),
                           i == frame_len - 1 || $urandom_range(0, 15) == 0);
            if ($urandom_range(0, 3) == 0)
            begin
                drain();
                write_register(BRIGHTNESS_ADDR, $urandom_range(0, 1) ? {24'h0, pick_channel()}
                                                                     : $urandom());
            end
        end
        drain();
    endtask

    task automatic test_streaming_no_idle();
        idle_on = 1'b0;
        write_register(BRIGHTNESS_ADDR, {24'h0, 8'($urandom_range(0, 255))});
        for (int i = 0; i < STREAM_PIXELS; i++)
            send_pixel(pick_channel(), pick_channel(), pick_channel(), i % 4 == 3);
        drain();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        brightness_cfg  = 8'd255;
        idle_on         = 1'b0;
        errors          = 0;
        pixels_sent     = 0;
        frames_sent     = 0;
        bytes_checked   = 0;
        register_writes = 0;
        quiet_cycles    = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_full_brightness();
        test_brightness_levels();
        test_register_decode();
        test_random_frames();
        test_streaming_no_idle();

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d pixels in %0d frames, %0d output bytes, %0d register writes",
                 pixels_sent, frames_sent, bytes_checked, register_writes);
        $display("Brightness 0 to 255, unmapped writes, random stalls, and a no-idle stream");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: files.f
hdl/lsne_pkg.sv
hdl/lsne_lane.sv
hdl/lsne_serializer.sv
hdl/led_strip_nrz_frame_encoder_unit.sv
verif/testbench.sv
